// ===== sv/pvpt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the pending verdict packet table.
package pvpt_pkg;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_VERDICT = 2'd1,
    OP_PURGE   = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_QUEUED     = 4'd0,
    ST_FULL       = 4'd1,
    ST_NOLISTENER = 4'd2,
    ST_WRONGPEER  = 4'd3,
    ST_NOTFOUND   = 4'd4,
    ST_DROPPED    = 4'd5,
    ST_XMIT       = 4'd6,
    ST_REINJECT   = 4'd7,
    ST_DEADOWNER  = 4'd8,
    ST_PURGED     = 4'd9,
    ST_NONEPURGED = 4'd10,
    ST_IGNORED    = 4'd11
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_SCAN  = 2'd1,
    FSM_SHIFT = 2'd2,
    FSM_EMIT  = 2'd3
  } fsm_e;

  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 88;
  localparam int unsigned CountW   = 7;

endpackage

// ===== sv/pvpt_mem.sv =====
`timescale 1ns / 1ps
// Slot store: one write port, one registered read port.
module pvpt_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pending_verdict_packet_table.sv =====
`timescale 1ns / 1ps
// Top level of the pending verdict packet table: sequencer, counters, result register.
//
// Channel   Direction  Signals                                    Payload
// s_axis    in         tvalid/tready/tdata[103:0]/tuser[1:0]      request: operation, arguments
// m_axis    out        tvalid/tready/tdata[87:0]/tuser/tlast      result: ids, counts, status
// cfg       in         cfg_we_i/cfg_wdata_i[6:0]                  queue_limit
//
// Enqueue, wrong peer and ignored release finish in the accept cycle.
// Verdict: one slot read per cycle until the id is found, then one shift per
// cycle over the younger slots, then one result. Purge, and a release from
// the bound peer: one slot per cycle over all pending entries, held while
// results stall on m_axis. Reset clears the counters and binding; the slot
// store needs no clearing pass. A request is taken only in idle with the
// result register free or draining.
module pending_verdict_packet_table #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned HANDLE_BITS = 16,
  parameter int unsigned OWNER_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // buffer_handle[15:0] owner_id[31:16] has_owner[32] listener_ok[33]
  // packet_id[65:34] verdict[66] peer_id[98:67] owner_dead[99] purge_all[100]
  input  logic [pvpt_pkg::InDataW-1:0]   s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_packet_id[31:0] result_handle[47:32] queued_count[54:48]
  // dropped_count[86:55]
  output logic [pvpt_pkg::OutDataW-1:0]  m_axis_tdata,
  // status[3:0]
  output logic [3:0]                     m_axis_tuser,
  output logic                           m_axis_tlast,
  input  logic                           cfg_we_i,
  input  logic [6:0]                     cfg_wdata_i
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = 32 + OWNER_BITS + 1 + HANDLE_BITS;
  localparam int unsigned HL = 0;
  localparam int unsigned OD = HANDLE_BITS;
  localparam int unsigned OL = HANDLE_BITS + 1;
  localparam int unsigned IL = HANDLE_BITS + 1 + OWNER_BITS;

  // request fields
  pvpt_pkg::op_e          in_op;
  logic [15:0]            in_handle;
  logic [15:0]            in_owner;
  logic                   in_has_owner, in_listener, in_verdict, in_dead, in_all;
  logic [31:0]            in_pkt, in_peer;
  logic [HANDLE_BITS-1:0] in_handle_m;
  logic [OWNER_BITS-1:0]  in_owner_m;

  assign in_op        = pvpt_pkg::op_e'(s_axis_tuser);
  assign in_handle    = s_axis_tdata[15:0];
  assign in_owner     = s_axis_tdata[31:16];
  assign in_has_owner = s_axis_tdata[32];
  assign in_listener  = s_axis_tdata[33];
  assign in_pkt       = s_axis_tdata[65:34];
  assign in_verdict   = s_axis_tdata[66];
  assign in_peer      = s_axis_tdata[98:67];
  assign in_dead      = s_axis_tdata[99];
  assign in_all       = s_axis_tdata[100];
  assign in_handle_m  = HANDLE_BITS'(32'(in_handle));
  assign in_owner_m   = OWNER_BITS'(32'(in_owner));

  // state
  pvpt_pkg::fsm_e         state_q, state_d;
  pvpt_pkg::op_e          op_q, op_d;
  logic [6:0]             limit_q;
  logic [31:0]            next_id_q, next_id_d, drop_q, drop_d, bound_q, bound_d;
  logic [CW-1:0]          pend_q, pend_d, ptr_q, ptr_d, wr_q, wr_d, n_q, n_d;
  logic [31:0]            pkt_q, pkt_d;
  logic                   rel_q, rel_d, dead_q, dead_d, all_q, all_d;
  logic [OWNER_BITS-1:0]  own_q, own_d;
  logic                   found_q, found_d, f_owned_q, f_owned_d;
  logic [HANDLE_BITS-1:0] f_handle_q, f_handle_d;
  // held purge result, sent once it is known whether it is the last
  logic                   hold_v_q, hold_v_d;
  logic [31:0]            hold_id_q, hold_id_d, hold_drop_q, hold_drop_d;
  logic [HANDLE_BITS-1:0] hold_h_q, hold_h_d;
  logic [CW-1:0]          hold_n_q, hold_n_d;

  // result register
  logic                   m_valid_q;
  logic [3:0]             m_status_q;
  logic [31:0]            m_id_q, m_drop_q;
  logic [15:0]            m_handle_q;
  logic [6:0]             m_count_q;
  logic                   m_last_q;

  // memory port
  logic                   mem_we;
  logic [IW-1:0]          mem_waddr, mem_raddr;
  logic [EW-1:0]          mem_wdata, mem_rdata;

  logic                   out_free, in_acc, scan_end, v_hit, p_hit, stall;
  logic [6:0]             lim;
  logic                   load;
  pvpt_pkg::status_e      o_status;
  logic [31:0]            o_id, o_drop;
  logic [HANDLE_BITS-1:0] o_handle;
  logic [CW-1:0]          o_count;
  logic                   o_last;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == pvpt_pkg::FSM_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign lim           = (limit_q > 7'(DEPTH)) ? 7'(DEPTH) : limit_q;
  assign scan_end      = ptr_q >= n_q;
  assign v_hit         = mem_rdata[EW-1:IL] == pkt_q;
  assign p_hit         = all_q || (mem_rdata[OD] && mem_rdata[IL-1:OL] == own_q);
  assign stall         = !scan_end && p_hit && hold_v_q && !out_free;

  pvpt_mem #(
    .DEPTH(DEPTH),
    .WIDTH(EW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pvpt_pkg::FSM_IDLE: begin
        if (in_acc) begin
          if (in_op == pvpt_pkg::OP_PURGE) begin
            state_d = pvpt_pkg::FSM_SCAN;
          end else if (in_op == pvpt_pkg::OP_VERDICT) begin
            if (bound_q == 32'd0 || bound_q == in_peer) state_d = pvpt_pkg::FSM_SCAN;
          end else if (in_op == pvpt_pkg::OP_RELEASE) begin
            if (in_peer == bound_q) state_d = pvpt_pkg::FSM_SCAN;
          end
        end
      end
      pvpt_pkg::FSM_SCAN: begin
        if (op_q == pvpt_pkg::OP_VERDICT) begin
          if (scan_end) state_d = pvpt_pkg::FSM_EMIT;
          else if (v_hit) state_d = pvpt_pkg::FSM_SHIFT;
        end else if (scan_end && out_free) begin
          state_d = pvpt_pkg::FSM_IDLE;
        end
      end
      pvpt_pkg::FSM_SHIFT: begin
        if (scan_end) state_d = pvpt_pkg::FSM_EMIT;
      end
      pvpt_pkg::FSM_EMIT: begin
        if (out_free) state_d = pvpt_pkg::FSM_IDLE;
      end
      default: state_d = pvpt_pkg::FSM_IDLE;
    endcase
  end

  // datapath and result selection
  always_comb begin
    op_d = op_q;   next_id_d = next_id_q; drop_d = drop_q; bound_d = bound_q;
    pend_d = pend_q; ptr_d = ptr_q; wr_d = wr_q; n_d = n_q; pkt_d = pkt_q;
    rel_d = rel_q; dead_d = dead_q; all_d = all_q; own_d = own_q;
    found_d = found_q; f_owned_d = f_owned_q; f_handle_d = f_handle_q;
    hold_v_d = hold_v_q; hold_id_d = hold_id_q; hold_drop_d = hold_drop_q;
    hold_h_d = hold_h_q; hold_n_d = hold_n_q;
    load = 1'b0; o_status = pvpt_pkg::ST_QUEUED; o_id = 32'd0; o_handle = '0;
    o_count = pend_q; o_drop = drop_q; o_last = 1'b1;
    mem_we = 1'b0; mem_waddr = wr_q[IW-1:0]; mem_wdata = mem_rdata;
    mem_raddr = IW'(ptr_q + CW'(1));
    unique case (state_q)
      pvpt_pkg::FSM_IDLE: begin
        mem_raddr = '0;
        if (in_acc) begin
          op_d = in_op; pkt_d = in_pkt; rel_d = in_verdict; dead_d = in_dead;
          all_d = in_all; own_d = in_owner_m;
          ptr_d = '0; wr_d = '0; n_d = pend_q; hold_v_d = 1'b0;
          unique case (in_op)
            pvpt_pkg::OP_ENQUEUE: begin
              load = 1'b1; o_id = next_id_q; o_handle = in_handle_m;
              next_id_d = next_id_q + 32'd1;
              if (7'(pend_q) >= lim) begin
                drop_d = drop_q + 32'd1; o_status = pvpt_pkg::ST_FULL;
              end else if (!in_listener) begin
                drop_d = drop_q + 32'd1; o_status = pvpt_pkg::ST_NOLISTENER;
              end else begin
                mem_we = 1'b1; mem_waddr = pend_q[IW-1:0];
                mem_wdata = {next_id_q, in_owner_m, in_has_owner, in_handle_m};
                pend_d = pend_q + CW'(1);
              end
            end
            pvpt_pkg::OP_VERDICT: begin
              if (bound_q != 32'd0 && bound_q != in_peer) begin
                load = 1'b1; o_status = pvpt_pkg::ST_WRONGPEER; o_id = in_pkt;
              end else if (bound_q == 32'd0) begin
                bound_d = in_peer;
              end
            end
            pvpt_pkg::OP_PURGE: begin
            end
            pvpt_pkg::OP_RELEASE: begin
              if (in_peer == bound_q) begin
                all_d = 1'b1; bound_d = 32'd0;
              end else begin
                load = 1'b1; o_status = pvpt_pkg::ST_IGNORED;
              end
            end
            default: ;
          endcase
        end
      end
      pvpt_pkg::FSM_SCAN: begin
        if (op_q == pvpt_pkg::OP_VERDICT) begin
          found_d = 1'b0;
          if (!scan_end) begin
            ptr_d = ptr_q + CW'(1);
            if (v_hit) begin
              found_d = 1'b1; wr_d = ptr_q;
              f_handle_d = mem_rdata[OD-1:HL]; f_owned_d = mem_rdata[OD];
            end
          end
        end else if (scan_end) begin
          if (out_free) begin
            load = 1'b1;
            if (hold_v_q) begin
              o_status = pvpt_pkg::ST_PURGED; o_id = hold_id_q; o_handle = hold_h_q;
              o_count = hold_n_q; o_drop = hold_drop_q;
            end else begin
              o_status = pvpt_pkg::ST_NONEPURGED;
            end
          end
        end else if (stall) begin
          // hold the current entry until the held result drains
          mem_raddr = ptr_q[IW-1:0];
        end else if (p_hit) begin
          ptr_d = ptr_q + CW'(1);
          pend_d = pend_q - CW'(1);
          drop_d = drop_q + 32'd1;
          if (hold_v_q) begin
            load = 1'b1; o_last = 1'b0; o_status = pvpt_pkg::ST_PURGED;
            o_id = hold_id_q; o_handle = hold_h_q; o_count = hold_n_q;
            o_drop = hold_drop_q;
          end
          hold_v_d = 1'b1; hold_id_d = mem_rdata[EW-1:IL];
          hold_h_d = mem_rdata[OD-1:HL]; hold_n_d = pend_d; hold_drop_d = drop_d;
        end else begin
          ptr_d = ptr_q + CW'(1);
          wr_d = wr_q + CW'(1);
          mem_we = wr_q != ptr_q;
        end
      end
      pvpt_pkg::FSM_SHIFT: begin
        if (!scan_end) begin
          mem_we = 1'b1;
          ptr_d = ptr_q + CW'(1);
          wr_d = wr_q + CW'(1);
        end
      end
      pvpt_pkg::FSM_EMIT: begin
        if (out_free) begin
          load = 1'b1; o_id = pkt_q;
          if (!found_q) begin
            o_status = pvpt_pkg::ST_NOTFOUND;
          end else begin
            pend_d = pend_q - CW'(1);
            o_handle = f_handle_q;
            if (!rel_q) begin
              o_status = pvpt_pkg::ST_DROPPED; drop_d = drop_q + 32'd1;
            end else if (f_owned_q) begin
              if (dead_q) begin
                o_status = pvpt_pkg::ST_DEADOWNER; drop_d = drop_q + 32'd1;
              end else begin
                o_status = pvpt_pkg::ST_XMIT;
              end
            end else begin
              o_status = pvpt_pkg::ST_REINJECT;
            end
          end
          o_count = pend_d; o_drop = drop_d;
        end
      end
      default: ;
    endcase
    if (load && state_q != pvpt_pkg::FSM_SCAN && state_q != pvpt_pkg::FSM_EMIT) begin
      o_count = pend_d; o_drop = drop_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pvpt_pkg::FSM_IDLE;
      limit_q   <= 7'd64;
      next_id_q <= '0;
      drop_q    <= '0;
      bound_q   <= '0;
      pend_q    <= '0;
      hold_v_q  <= 1'b0;
      m_valid_q <= 1'b0;
      op_q      <= pvpt_pkg::OP_ENQUEUE;
      ptr_q     <= '0;
      wr_q      <= '0;
      n_q       <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      next_id_q <= next_id_d;
      drop_q    <= drop_d;
      bound_q   <= bound_d;
      pend_q    <= pend_d;
      hold_v_q  <= hold_v_d;
      op_q      <= op_d;
      ptr_q     <= ptr_d;
      wr_q      <= wr_d;
      n_q       <= n_d;
      found_q   <= found_d;
      if (load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_q <= pkt_d; rel_q <= rel_d; dead_q <= dead_d; all_q <= all_d; own_q <= own_d;
    f_owned_q <= f_owned_d; f_handle_q <= f_handle_d;
    hold_id_q <= hold_id_d; hold_drop_q <= hold_drop_d; hold_h_q <= hold_h_d;
    hold_n_q <= hold_n_d;
    if (load) begin
      m_status_q <= o_status;
      m_id_q     <= o_id;
      m_handle_q <= 16'(32'(o_handle));
      m_count_q  <= 7'(o_count);
      m_drop_q   <= o_drop;
      m_last_q   <= o_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_drop_q, m_count_q, m_handle_q, m_id_q};
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ===== sv/pvpt_chk.sv =====
`timescale 1ns / 1ps
// Port checker for the pending verdict packet table, bound to the top level.
module pvpt_chk #(
  parameter int unsigned DEPTH = 64
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pvpt_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [3:0]                    m_axis_tuser,
  input logic                          m_axis_tlast
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[54:48] <= 7'(DEPTH))
    else $error("queued count above depth");

  // single-result requests always close their frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == pvpt_pkg::ST_QUEUED
      || m_axis_tuser == pvpt_pkg::ST_FULL || m_axis_tuser == pvpt_pkg::ST_IGNORED
      || m_axis_tuser == pvpt_pkg::ST_NONEPURGED
      || m_axis_tuser == pvpt_pkg::ST_WRONGPEER) |-> m_axis_tlast)
    else $error("single result without last");

  // a frame of purge results is open: no new request taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("request taken inside a result frame");

endmodule

bind pending_verdict_packet_table pvpt_chk #(.DEPTH(DEPTH)) u_pvpt_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
